>>> rtl/rwtc_pkg.sv
// Package of the ray compositor: field widths, register indexes and the
// status type shared between the top level and its divider.
// Depends on nothing.

package rwtc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int WSUM_W    = 48;
	localparam int WGT_W     = 32;
	localparam int LIMIT_W   = 20;
	localparam int SHIFT_W   = 4;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 2 * SAMPLE_W;

	// One quotient bit is produced per divider step.
	localparam int DIV_STEPS = WSUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [SAMPLE_W-1:0] LOW_RESET   = 16'd0;
	localparam logic [SAMPLE_W-1:0] HIGH_RESET  = 16'd65535;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 20'd1024;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET = 4'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THRESHOLD  = 2'd0,
		REG_HIGH_THRESHOLD = 2'd1,
		REG_WEIGHT_LIMIT   = 2'd2,
		REG_WEIGHT_SHIFT   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/rwtc_if.sv
// Handshake interfaces of the ray compositor: the sample channel and the
// pixel channel. Depends on rwtc_pkg for the field widths.

interface rwtc_sample_if;
	logic                               valid;
	logic                               ready;
	logic [rwtc_pkg::SAMPLE_W-1:0]      sample_value;
	logic                               ray_end;

	modport source (output valid, output sample_value, output ray_end, input ready);
	modport sink   (input valid, input sample_value, input ray_end, output ready);
endinterface

interface rwtc_pixel_if;
	logic                               valid;
	logic                               ready;
	logic [rwtc_pkg::SAMPLE_W-1:0]      pixel_value;
	logic                               is_transparent;
	logic                               stopped_early;

	modport source (output valid, output pixel_value, output is_transparent,
		output stopped_early, input ready);
	modport sink   (input valid, input pixel_value, input is_transparent,
		input stopped_early, output ready);
endinterface

>>> rtl/rwtc_divider.sv
// Restoring divider of the ray compositor, one quotient bit per cycle.
// Depends on rwtc_pkg.

module rwtc_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rwtc_pkg::WSUM_W-1:0]       dividend,
	input  logic [rwtc_pkg::WGT_W-1:0]        divisor,
	output rwtc_pkg::div_stat_t               stat,
	output logic [rwtc_pkg::SAMPLE_W-1:0]     quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [rwtc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [rwtc_pkg::WGT_W-1:0]        rem_q;
	logic [rwtc_pkg::WSUM_W-1:0]       dvd_q;
	logic [rwtc_pkg::WGT_W-1:0]        dvs_q;
	logic [rwtc_pkg::WGT_W:0]          trial;
	logic [rwtc_pkg::WGT_W:0]          diff;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, dvd_q[rwtc_pkg::WSUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rwtc_pkg::DIV_CNT_W'(rwtc_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[rwtc_pkg::WGT_W]) begin
				rem_q <= diff[rwtc_pkg::WGT_W-1:0];
				dvd_q <= {dvd_q[rwtc_pkg::WSUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[rwtc_pkg::WGT_W-1:0];
				dvd_q <= {dvd_q[rwtc_pkg::WSUM_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q[rwtc_pkg::SAMPLE_W-1:0];

endmodule

>>> rtl/ray_weighted_threshold_compositor_unit.sv
// Top level of the ray compositor: sequencer, shared multiply-add datapath,
// configuration registers and output register. Depends on rwtc_pkg, rwtc_if
// and rwtc_divider.

// The unit takes the samples of one ray front to back on the sample channel
// and emits one pixel per ray, after the beat that carries ray_end. A sample
// counts when it lies inside the window set by low_threshold and
// high_threshold; its weight is the sample shifted right by weight_shift,
// rounded up. The unit keeps the sum of value times weight and the sum of
// weights, and once the weight sum reaches weight_limit the rest of the ray
// is ignored; the pixel reports stopped_early when that happened before the
// ray's last beat. The pixel is the weighted sum divided by the weight sum
// (zero when the weight sum is zero) and is marked transparent when it falls
// outside the window. One sample beat passes through the accept, multiply
// and accumulate steps. A beat with ray_end also runs the restoring divider,
// one quotient bit per cycle over 48 steps; when the weight sum is zero the
// divider is skipped. The finished pixel sits in an output register, so the
// next ray can start while the pixel still waits to be taken; a ray that
// ends while that register is still full waits in its final state until the
// pixel is taken. Configuration writes are taken at any time but are meant
// to be made while the unit is idle.

module ray_weighted_threshold_compositor_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	rwtc_sample_if.sink                          sample,
	rwtc_pixel_if.source                         pixel,
	input  logic                                 cfg_we,
	input  logic [rwtc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rwtc_pkg::CFG_W-1:0]           cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                              state_q;

	// Configuration registers.
	logic [rwtc_pkg::SAMPLE_W-1:0]       low_q;
	logic [rwtc_pkg::SAMPLE_W-1:0]       high_q;
	logic [rwtc_pkg::LIMIT_W-1:0]        limit_q;
	logic [rwtc_pkg::SHIFT_W-1:0]        shift_q;

	// Ray state.
	logic [rwtc_pkg::WSUM_W-1:0]         wsum_q;
	logic [rwtc_pkg::WGT_W-1:0]          wgt_q;
	logic                                ray_done_q;

	// Per-sample working registers.
	logic [rwtc_pkg::SAMPLE_W-1:0]       value_q;
	logic                                last_q;
	logic                                counted_q;
	logic                                done_before_q;
	logic [rwtc_pkg::SAMPLE_W-1:0]       weight_q;
	logic [rwtc_pkg::PROD_W-1:0]         prod_q;
	logic [rwtc_pkg::SAMPLE_W-1:0]       res_q;

	// Output register.
	logic                                pix_valid_q;
	logic [rwtc_pkg::SAMPLE_W-1:0]       pix_value_q;
	logic                                pix_transp_q;
	logic                                pix_early_q;

	logic                                in_beat;
	logic                                in_window;
	logic [rwtc_pkg::SAMPLE_W:0]         round_add;
	logic [rwtc_pkg::SAMPLE_W:0]         weight_full;
	logic [rwtc_pkg::WSUM_W:0]           wsum_add;
	logic [rwtc_pkg::WGT_W:0]            wgt_add;
	logic [rwtc_pkg::WSUM_W-1:0]         wsum_next;
	logic [rwtc_pkg::WGT_W-1:0]          wgt_next;
	logic                                div_start;
	logic                                out_free;
	logic                                pix_load;
	rwtc_pkg::div_stat_t                 div_stat;
	logic [rwtc_pkg::SAMPLE_W-1:0]       div_quot;

	assign sample.ready = (state_q == ST_IDLE);
	assign in_beat      = sample.valid && sample.ready;
	assign in_window    = (sample.sample_value >= low_q) && (sample.sample_value <= high_q);

	// Weight is the value shifted right with rounding up; it always fits the
	// sample width because a carry out only happens for shifts of one or more.
	assign round_add   = {1'b0, value_q} +
		(((rwtc_pkg::SAMPLE_W+1)'(1) << shift_q) - (rwtc_pkg::SAMPLE_W+1)'(1));
	assign weight_full = round_add >> shift_q;

	// Saturating accumulation; the limit keeps the sums far below their widths.
	assign wsum_add  = {1'b0, wsum_q} + (rwtc_pkg::WSUM_W+1)'(prod_q);
	assign wgt_add   = {1'b0, wgt_q} + (rwtc_pkg::WGT_W+1)'(weight_q);
	always_comb begin
		wsum_next = wsum_q;
		wgt_next  = wgt_q;
		if (counted_q) begin
			wsum_next = wsum_add[rwtc_pkg::WSUM_W] ? '1 : wsum_add[rwtc_pkg::WSUM_W-1:0];
			wgt_next  = wgt_add[rwtc_pkg::WGT_W] ? '1 : wgt_add[rwtc_pkg::WGT_W-1:0];
		end
	end

	assign div_start = (state_q == ST_ADD) && last_q && (wgt_next != '0);
	assign out_free  = !pix_valid_q || pixel.ready;
	assign pix_load  = (state_q == ST_OUT) && out_free;

	rwtc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum_next),
		.divisor  (wgt_next),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= rwtc_pkg::LOW_RESET;
			high_q  <= rwtc_pkg::HIGH_RESET;
			limit_q <= rwtc_pkg::LIMIT_RESET;
			shift_q <= rwtc_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (rwtc_pkg::cfg_reg_t'(cfg_index))
				rwtc_pkg::REG_LOW_THRESHOLD:  low_q   <= cfg_data[rwtc_pkg::SAMPLE_W-1:0];
				rwtc_pkg::REG_HIGH_THRESHOLD: high_q  <= cfg_data[rwtc_pkg::SAMPLE_W-1:0];
				rwtc_pkg::REG_WEIGHT_LIMIT:   limit_q <= cfg_data[rwtc_pkg::LIMIT_W-1:0];
				rwtc_pkg::REG_WEIGHT_SHIFT:   shift_q <= cfg_data[rwtc_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the ray state and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wsum_q      <= '0;
			wgt_q       <= '0;
			ray_done_q  <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			// A new pixel may replace one that is taken in the same cycle.
			if (pix_load) begin
				pix_valid_q <= 1'b1;
			end else if (pix_valid_q && pixel.ready) begin
				pix_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (last_q) begin
						// The divider has taken its operands; start the next ray clean.
						wsum_q     <= '0;
						wgt_q      <= '0;
						ray_done_q <= 1'b0;
						state_q    <= (wgt_next != '0) ? ST_DIV : ST_OUT;
					end else begin
						wsum_q <= wsum_next;
						wgt_q  <= wgt_next;
						if (counted_q && (wgt_next >= rwtc_pkg::WGT_W'(limit_q))) begin
							ray_done_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			value_q       <= sample.sample_value;
			last_q        <= sample.ray_end;
			counted_q     <= !ray_done_q && in_window;
			done_before_q <= ray_done_q;
		end
		if (state_q == ST_MUL) begin
			weight_q <= weight_full[rwtc_pkg::SAMPLE_W-1:0];
			prod_q   <= value_q * weight_full[rwtc_pkg::SAMPLE_W-1:0];
		end
		if ((state_q == ST_ADD) && (wgt_next == '0)) begin
			res_q <= '0;
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			res_q <= div_quot;
		end
		if (pix_load) begin
			pix_value_q  <= res_q;
			pix_transp_q <= (res_q < low_q) || (res_q > high_q);
			pix_early_q  <= done_before_q;
		end
	end

	assign pixel.valid          = pix_valid_q;
	assign pixel.pixel_value    = pix_value_q;
	assign pixel.is_transparent = pix_transp_q;
	assign pixel.stopped_early  = pix_early_q;

endmodule

>>> rtl/rwtc_checker.sv
// Port-level checker of the ray compositor and its bind to the top level.
// Depends on rwtc_pkg and ray_weighted_threshold_compositor_unit.

module rwtc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              in_ray_end,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [rwtc_pkg::SAMPLE_W-1:0]     out_pixel_value,
	input  logic                              out_is_transparent,
	input  logic                              out_stopped_early
);

	// The unit is never ready again in the cycle after a sample beat.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample channel ready right after a beat");

	// A sample that does not end its ray frees the unit once it has passed the multiply and add states.
	a_mid_ray_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_ray_end) |=> ##2 in_ready)
		else $error("mid-ray sample did not return to idle in time");

	// No pixel can appear in the cycle right after a sample beat.
	a_no_instant_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("pixel appeared directly after a sample beat");

	// A stalled pixel keeps its payload.
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_pixel_value) &&
			$stable(out_is_transparent) && $stable(out_stopped_early)))
		else $error("stalled pixel changed");

endmodule

bind ray_weighted_threshold_compositor_unit rwtc_checker u_rwtc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (sample.valid),
	.in_ready           (sample.ready),
	.in_ray_end         (sample.ray_end),
	.out_valid          (pixel.valid),
	.out_ready          (pixel.ready),
	.out_pixel_value    (pixel.pixel_value),
	.out_is_transparent (pixel.is_transparent),
	.out_stopped_early  (pixel.stopped_early)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench of the ray compositor: streams sample beats, predicts every pixel
// with a model of its own and checks the pixel channel against it.
// Depends on rwtc_pkg, the rwtc_if interfaces and the compositor top level.

module tb_top;
	import rwtc_pkg::*;

	// One beat on the sample channel and one beat on the pixel channel.
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                ray_end;
	} ray_sample_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                transparent;
		logic                early;
	} ray_pixel_t;

	localparam logic [WSUM_W-1:0] WSUM_SAT = '1;
	localparam logic [WGT_W-1:0]  WGT_SAT  = '1;

	// The last beat of a ray runs the 48-step divider before its pixel appears.
	// The settle time is waited out only after every pixel is back.
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 146;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_THRESHOLD;
	logic [CFG_W-1:0]     cfg_data  = '0;

	rwtc_sample_if smp ();
	rwtc_pixel_if  pix ();

	ray_weighted_threshold_compositor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.pixel     (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our copy of the register file, updated as each write is made.
	logic [SAMPLE_W-1:0] win_low      = LOW_RESET;
	logic [SAMPLE_W-1:0] win_high     = HIGH_RESET;
	logic [LIMIT_W-1:0]  stop_weight  = LIMIT_RESET;
	logic [SHIFT_W-1:0]  weight_shift = SHIFT_RESET;

	// Per-ray accumulation state of the compositing model.
	logic [WSUM_W-1:0] acc_weighted = '0;
	logic [WGT_W-1:0]  acc_weight   = '0;
	logic              ray_stopped  = 1'b0;

	ray_sample_t sample_q[$];       // beats waiting to be driven
	ray_pixel_t  pixel_expect_q[$]; // predicted pixels, oldest first

	int samples_queued  = 0;
	int samples_taken   = 0;
	int pixels_checked  = 0;
	int rays_early      = 0;
	int pixels_clear    = 0;
	int settings_used   = 1;
	int mismatches      = 0;

	// Idling controls, changed only between phases.
	logic src_gaps_on   = 1'b0;
	logic snk_stalls_on = 1'b0;

	// Compositing model: one call per accepted sample beat. A sample inside
	// the window adds value * weight and weight, where the weight is the
	// sample shifted right with rounding up. Once the weight sum reaches the
	// limit the ray is marked stopped and further samples only count for
	// their ray_end mark. On ray_end the pixel is the integer quotient.
	function automatic void composite_sample(input ray_sample_t s);
		logic [SAMPLE_W:0]   round_up;
		logic [SAMPLE_W:0]   weight;
		logic [PROD_W-1:0]   product;
		logic [WSUM_W:0]     wsum_next;
		logic [WGT_W:0]      wgt_next;
		logic [WSUM_W-1:0]   quotient;
		logic                stopped_before;
		ray_pixel_t          px;

		stopped_before = ray_stopped;
		if (!ray_stopped && s.value >= win_low && s.value <= win_high) begin
			round_up  = (SAMPLE_W+1)'(1) << weight_shift;
			round_up  = round_up - 1'b1;
			weight    = ({1'b0, s.value} + round_up) >> weight_shift;
			product   = s.value * weight[SAMPLE_W-1:0];
			wsum_next = {1'b0, acc_weighted} + product;
			wgt_next  = {1'b0, acc_weight} + weight;
			// The sums cannot really overflow, but they saturate as a guard.
			acc_weighted = wsum_next[WSUM_W] ? WSUM_SAT : wsum_next[WSUM_W-1:0];
			acc_weight   = wgt_next[WGT_W] ? WGT_SAT : wgt_next[WGT_W-1:0];
			if (acc_weight >= stop_weight)
				ray_stopped = 1'b1;
		end

		if (s.ray_end) begin
			quotient       = (acc_weight != '0) ? acc_weighted / acc_weight : '0;
			px.value       = quotient[SAMPLE_W-1:0];
			px.transparent = (px.value < win_low) || (px.value > win_high);
			// Only a stop on an earlier beat of the ray counts as early.
			px.early       = stopped_before;
			pixel_expect_q.push_back(px);
			acc_weighted = '0;
			acc_weight   = '0;
			ray_stopped  = 1'b0;
		end
	endfunction

	// Sample driver. An item stays on the channel until it is taken; after
	// each beat the source may hold off for a random number of cycles.
	ray_sample_t cur_beat = '0;
	logic        holding  = 1'b0;
	int          src_gap  = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready) begin
				composite_sample(cur_beat);
				samples_taken++;
				holding = 1'b0;
				src_gap = src_gaps_on ? $urandom_range(0, 9) : 0;
			end
			if (!holding) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (sample_q.size() != 0) begin
					cur_beat = sample_q.pop_front();
					holding  = 1'b1;
				end
			end
			smp.valid        <= holding;
			smp.sample_value <= cur_beat.value;
			smp.ray_end      <= cur_beat.ray_end;
		end
	end

	// Pixel monitor. Every pixel beat is compared with the oldest prediction;
	// after each beat the sink may stall ready for a random number of cycles.
	int stall_left = 0;

	always @(posedge clk) begin
		ray_pixel_t got;
		ray_pixel_t want;

		if (!arst_n) begin
			pix.ready <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				got.value       = pix.pixel_value;
				got.transparent = pix.is_transparent;
				got.early       = pix.stopped_early;
				if (pixel_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: pixel %0d with no ray pending (transparent %0b, early %0b)",
							$realtime, got.value, got.transparent, got.early);
				end else begin
					want = pixel_expect_q.pop_front();
					pixels_checked++;
					rays_early   += want.early;
					pixels_clear += want.transparent;
					if (got.value !== want.value || got.transparent !== want.transparent ||
						got.early !== want.early) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: pixel mismatch: expected value %0d transparent %0b ",
								$realtime, want.value, want.transparent,
								"early %0b, got value %0d transparent %0b early %0b",
								want.early, got.value, got.transparent, got.early);
					end
				end
				stall_left = snk_stalls_on ? $urandom_range(0, 9) : 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				pix.ready <= 1'b0;
			end else begin
				pix.ready <= 1'b1;
			end
		end
	end

	// Register write: the unit takes it at the edge after the one that drives
	// it. Writes are only made while the unit is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOW_THRESHOLD:  win_low      = data[SAMPLE_W-1:0];
			REG_HIGH_THRESHOLD: win_high     = data[SAMPLE_W-1:0];
			REG_WEIGHT_LIMIT:   stop_weight  = data[LIMIT_W-1:0];
			REG_WEIGHT_SHIFT:   weight_shift = data[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all four registers. The unused upper bits of the narrow
	// registers carry random junk, which the unit must drop.
	task automatic set_window(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
		input logic [LIMIT_W-1:0] lim, input logic [SHIFT_W-1:0] sh);
		write_reg(REG_LOW_THRESHOLD, {(CFG_W-SAMPLE_W)'($urandom), lo});
		write_reg(REG_HIGH_THRESHOLD, {(CFG_W-SAMPLE_W)'($urandom), hi});
		write_reg(REG_WEIGHT_LIMIT, lim);
		write_reg(REG_WEIGHT_SHIFT, {(CFG_W-SHIFT_W)'($urandom), sh});
		settings_used++;
	endtask

	task automatic random_settings();
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [LIMIT_W-1:0]  lim;
		logic [SHIFT_W-1:0]  sh;

		case ($urandom_range(0, 4))
			0: begin
				lo = LOW_RESET;
				hi = HIGH_RESET;
			end
			1: begin
				lo = $urandom_range(0, 40000);
				hi = $urandom_range(lo, 65535);
			end
			2: begin
				lo = $urandom_range(0, 65000);
				hi = lo + $urandom_range(0, 500);
			end
			3: begin
				// Empty window: nothing can count.
				lo = $urandom_range(1, 65535);
				hi = $urandom_range(0, lo - 1);
			end
			default: begin
				lo = SAMPLE_W'($urandom);
				hi = SAMPLE_W'($urandom);
			end
		endcase
		case ($urandom_range(0, 5))
			0: lim = '0;
			1: lim = '1;
			2: lim = LIMIT_RESET;
			3: lim = $urandom_range(1, 4096);
			4: lim = $urandom_range(0, 200000);
			default: lim = LIMIT_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: sh = '0;
			1: sh = '1;
			default: sh = SHIFT_W'($urandom);
		endcase
		set_window(lo, hi, lim, sh);
	endtask

	task automatic pick_idling(input logic src_on, input logic snk_on);
		src_gaps_on   <= src_on;
		snk_stalls_on <= snk_on;
	endtask

	task automatic queue_sample(input logic [SAMPLE_W-1:0] v, input logic ray_end);
		ray_sample_t s;

		s.value   = v;
		s.ray_end = ray_end;
		sample_q.push_back(s);
		samples_queued++;
	endtask

	// Sample values lean on the window edges and the field extremes so that
	// both sides of every comparison are hit often.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return win_low;
			3: return win_high;
			4: return win_low - 1'b1;
			5: return win_high + 1'b1;
			6, 7: return (win_low <= win_high) ?
				SAMPLE_W'($urandom_range(win_high, win_low)) : SAMPLE_W'($urandom);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly short rays, with an occasional long one that can run into the
	// weight limit. Every ray ends with a ray_end beat.
	task automatic queue_random_rays(input int n);
		int len;
		int placed;

		placed = 0;
		while (placed < n) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				queue_sample(pick_sample(), k == len - 1);
			placed += len;
		end
	endtask

	// Waits until every beat is taken and every pixel is back, then lets the
	// unit settle so that a register write cannot land mid-ray.
	task automatic wait_idle();
		while (samples_taken != samples_queued || pixel_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sel;

		smp.valid        = 1'b0;
		smp.sample_value = '0;
		smp.ray_end      = 1'b0;
		pix.ready        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rays under the reset settings, without idling: an all-zero
		// sample, a full-scale sample whose stop falls on the ray end, a ray
		// that stops early and ignores its tail, and a ray that reaches the
		// limit exactly on its last sample.
		pick_idling(1'b0, 1'b0);
		@(negedge clk);
		queue_sample(0, 1'b1);
		queue_sample('1, 1'b1);
		queue_sample(100, 1'b0);
		queue_sample(2000, 1'b0);
		queue_sample(5, 1'b0);
		queue_sample(7, 1'b1);
		queue_sample(1, 1'b0);
		queue_sample(1023, 1'b1);
		wait_idle();

		// Empty window: low above high, so nothing counts and the zero pixel
		// is transparent.
		pick_idling(1'b1, 1'b1);
		set_window(5000, 4000, LIMIT_RESET, SHIFT_RESET);
		@(negedge clk);
		queue_sample(4500, 1'b0);
		queue_sample(6000, 1'b1);
		wait_idle();

		// Zero weight limit: the first counted sample, even of weight zero,
		// ends the ray.
		set_window(LOW_RESET, HIGH_RESET, '0, SHIFT_RESET);
		@(negedge clk);
		queue_sample(0, 1'b0);
		queue_sample(300, 1'b1);
		wait_idle();

		// Largest shift and largest limit with a window that excludes both
		// neighbors of its edges; then a ray with nothing counted and a
		// window above zero, which gives a transparent zero pixel.
		set_window(1000, 60000, '1, '1);
		@(negedge clk);
		queue_sample(500, 1'b0);
		queue_sample(1000, 1'b0);
		queue_sample(60000, 1'b0);
		queue_sample(60001, 1'b0);
		queue_sample(32768, 1'b1);
		queue_sample(500, 1'b1);
		wait_idle();

		// Random phases. The first keeps the full window with the largest
		// limit and no shift, so that long rays build the largest sums.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sel = $urandom_range(0, 3);
			pick_idling(sel[0], sel[1]);
			if (p == 0)
				set_window(LOW_RESET, HIGH_RESET, '1, '0);
			else
				random_settings();
			@(negedge clk);
			queue_random_rays(PHASE_SAMPLES);
			wait_idle();
		end

		if (pixel_expect_q.size() != 0)
			mismatches += pixel_expect_q.size();

		$display("Ran %0d sample beats into %0d checked pixels over %0d register settings.",
			samples_taken, pixels_checked, settings_used);
		$display("Rays stopped early: %0d, transparent pixels: %0d, mismatches: %0d.",
			rays_early, pixels_clear, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
